@@ hw/rtl/response_status_code_extractor_defines.svh @@
// Assertion macros used by the checker of the status code extractor.
`ifndef RESPONSE_STATUS_CODE_EXTRACTOR_DEFINES_SVH
`define RESPONSE_STATUS_CODE_EXTRACTOR_DEFINES_SVH

// Checks in the same cycle that the consequent holds whenever the antecedent does.
`define RSCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks in the next cycle that the consequent holds after the antecedent.
`define RSCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rsce_pkg.sv @@
// Types, constants and the code scanner shared by the status code extractor.
`default_nettype none

package rsce_pkg;

    localparam int HEAD_DEPTH    = 12;
    localparam int POS_W         = 4;
    localparam int CODE_LEN      = 3;
    localparam int CODE_W        = 11;
    localparam int MAG_W         = 10;
    localparam int RTSP_CODE_POS = 9;
    localparam int FTP_CODE_POS  = 0;
    localparam int RTSP_TAG_LEN  = 5;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [7:0] RTSP_TAG [RTSP_TAG_LEN] = '{8'h52, 8'h54, 8'h53, 8'h50, 8'h2F};

    localparam logic MODE_RTSP = 1'b0;
    localparam logic MODE_FTP  = 1'b1;

    typedef enum logic [1:0] {
        SCAN_BLANK,
        SCAN_DIGITS,
        SCAN_DONE
    } t_scan_phase;

    // Decoded code: sign and up to three decimal digits, right aligned.
    typedef struct packed {
        logic       neg;
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } t_code_req;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {[8'h09:8'h0D], 8'h20};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // Walks the three code bytes: skip blanks, take one sign, then digits.
    function automatic t_code_req scan_code(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2);
        logic [7:0]  bytes [CODE_LEN];
        t_scan_phase phase;
        t_code_req   req;
        logic [3:0]  dig;
        bytes[0] = b0;
        bytes[1] = b1;
        bytes[2] = b2;
        phase    = SCAN_BLANK;
        req      = '0;
        for (int k = 0; k < CODE_LEN; k++) begin
            dig = 4'(bytes[k] - CHAR_ZERO);
            case (phase)
                SCAN_BLANK: begin
                    if (is_blank(bytes[k])) begin
                        phase = SCAN_BLANK;
                    end else if (bytes[k] == CHAR_PLUS || bytes[k] == CHAR_MINUS) begin
                        req.neg = (bytes[k] == CHAR_MINUS);
                        phase   = SCAN_DIGITS;
                    end else if (is_digit(bytes[k])) begin
                        req.hundreds = req.tens;
                        req.tens     = req.ones;
                        req.ones     = dig;
                        phase        = SCAN_DIGITS;
                    end else begin
                        phase = SCAN_DONE;
                    end
                end
                SCAN_DIGITS: begin
                    if (is_digit(bytes[k])) begin
                        req.hundreds = req.tens;
                        req.tens     = req.ones;
                        req.ones     = dig;
                    end else begin
                        phase = SCAN_DONE;
                    end
                end
                default: begin
                    phase = SCAN_DONE;
                end
            endcase
        end
        return req;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/response_status_code_extractor.sv @@
// Top level of the response status code extractor.
//
// The block takes one response byte per request and splits the stream into lines ending in
// CR LF, keeping the first twelve bytes of each line (positions not reached by a line keep
// stale bytes until a buffer end clears them). At each line end it reads a three byte code,
// atoi style (blanks, optional sign, digits): in RTSP mode (protocol_mode 0) from positions
// 9 to 11 of lines that start with "RTSP/", in FTP mode (protocol_mode 1) from positions 0
// to 2 of every line. A nonzero code gives one result request with the signed code; a zero
// code gives none and silences the block until the next buffer end. The block accepts one
// byte every cycle while o_stall is low. The front end updates the line state within the
// cycle a byte arrives and pushes each result into the queue as the closing LF is accepted.
// Results pass through a two entry queue into the output register; input is stalled only
// while that queue is full, which happens only when a stalled result waits in the output
// register with two more results queued behind it. protocol_mode is written through
// i_cfg_wr_en and i_cfg_wr_data by the user only while idle; the block never enforces it.
`default_nettype none

module response_status_code_extractor (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic                          i_cfg_wr_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_buffer_end,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [rsce_pkg::CODE_W-1:0] o_status_code
);

    logic                r_mode;
    logic                accept;
    logic                push;
    logic                pop;
    logic                q_not_empty;
    logic                q_full;
    rsce_pkg::t_code_req front_req;
    rsce_pkg::t_code_req head_req;

    // Protocol mode register; the user must write it only while idle, the block never checks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rsce_pkg::MODE_RTSP;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // A byte may always enter while the queue has room for the result it might produce.
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    rsce_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_buffer_end (i_buffer_end),
        .o_req        (front_req),
        .o_push       (push)
    );

    rsce_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_req   (front_req),
        .i_pop        (pop),
        .o_head_req   (head_req),
        .o_not_empty  (q_not_empty),
        .o_full       (q_full)
    );

    rsce_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (head_req),
        .i_req_valid   (q_not_empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status_code (o_status_code)
    );

endmodule

`default_nettype wire

@@ hw/rtl/rsce_front.sv @@
// Front end: line tracking, line head store and code classification per byte.
`default_nettype none

module rsce_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_mode,
    input  wire logic                i_accept,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_buffer_end,
    output rsce_pkg::t_code_req      o_req,
    output logic                     o_push
);

    logic [7:0]                  r_head [rsce_pkg::HEAD_DEPTH];
    logic [7:0]                  n_head [rsce_pkg::HEAD_DEPTH];
    logic [rsce_pkg::POS_W-1:0]  r_pos;
    logic [rsce_pkg::POS_W-1:0]  n_pos;
    logic                        r_prev_cr;
    logic                        n_prev_cr;
    logic                        r_stopped;
    logic                        n_stopped;

    logic                        line_end;
    logic                        tag_ok;
    logic                        take;
    logic                        nonzero;
    logic [7:0]                  rtsp_b [rsce_pkg::CODE_LEN];
    logic [7:0]                  ftp_b  [rsce_pkg::CODE_LEN];
    logic [7:0]                  code_b [rsce_pkg::CODE_LEN];

    // The code bytes as they look after this byte is stored.
    always_comb begin
        for (int j = 0; j < rsce_pkg::CODE_LEN; j++) begin
            rtsp_b[j] = (r_pos == rsce_pkg::POS_W'(rsce_pkg::RTSP_CODE_POS + j)) ?
                        i_data_byte : r_head[rsce_pkg::RTSP_CODE_POS + j];
            ftp_b[j]  = (r_pos == rsce_pkg::POS_W'(rsce_pkg::FTP_CODE_POS + j)) ?
                        i_data_byte : r_head[rsce_pkg::FTP_CODE_POS + j];
            code_b[j] = (i_mode == rsce_pkg::MODE_FTP) ? ftp_b[j] : rtsp_b[j];
        end
    end

    always_comb begin
        tag_ok = (r_pos >= rsce_pkg::POS_W'(rsce_pkg::RTSP_TAG_LEN));
        for (int k = 0; k < rsce_pkg::RTSP_TAG_LEN; k++) begin
            tag_ok = tag_ok && (r_head[k] == rsce_pkg::RTSP_TAG[k]);
        end
    end

    assign line_end = !r_stopped && (r_pos != '0) && r_prev_cr &&
                      (i_data_byte == rsce_pkg::CHAR_LF);
    assign take     = (i_mode == rsce_pkg::MODE_FTP) || tag_ok;
    assign o_req    = rsce_pkg::scan_code(code_b[0], code_b[1], code_b[2]);
    assign nonzero  = (o_req.hundreds != '0) || (o_req.tens != '0) || (o_req.ones != '0);
    assign o_push   = i_accept && line_end && take && nonzero;

    always_comb begin
        n_head    = r_head;
        n_pos     = r_pos;
        n_prev_cr = r_prev_cr;
        n_stopped = r_stopped;
        if (i_accept) begin
            if (!r_stopped) begin
                for (int k = 0; k < rsce_pkg::HEAD_DEPTH; k++) begin
                    if (r_pos == rsce_pkg::POS_W'(k)) begin
                        n_head[k] = i_data_byte;
                    end
                end
                if (line_end) begin
                    n_pos     = '0;
                    n_prev_cr = 1'b0;
                    if (take && !nonzero) begin
                        n_stopped = 1'b1;
                    end
                end else begin
                    if (r_pos < rsce_pkg::POS_W'(rsce_pkg::HEAD_DEPTH)) begin
                        n_pos = r_pos + 1'b1;
                    end
                    n_prev_cr = (i_data_byte == rsce_pkg::CHAR_CR);
                end
            end
            if (i_buffer_end) begin
                for (int k = 0; k < rsce_pkg::HEAD_DEPTH; k++) begin
                    n_head[k] = '0;
                end
                n_pos     = '0;
                n_prev_cr = 1'b0;
                n_stopped = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rsce_pkg::HEAD_DEPTH; k++) begin
                r_head[k] <= '0;
            end
            r_pos     <= '0;
            r_prev_cr <= 1'b0;
            r_stopped <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_pos     <= n_pos;
            r_prev_cr <= n_prev_cr;
            r_stopped <= n_stopped;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rsce_queue.sv @@
// Short request queue between the front end and the back end.
`default_nettype none

module rsce_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire rsce_pkg::t_code_req i_push_req,
    input  wire logic                i_pop,
    output rsce_pkg::t_code_req      o_head_req,
    output logic                     o_not_empty,
    output logic                     o_full
);

    rsce_pkg::t_code_req          r_entry [rsce_pkg::QUEUE_DEPTH];
    logic [rsce_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [rsce_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [rsce_pkg::QCNT_W-1:0]  r_count;
    logic [rsce_pkg::QCNT_W-1:0]  n_count;

    assign o_head_req  = r_entry[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_full      = (r_count == rsce_pkg::QCNT_W'(rsce_pkg::QUEUE_DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == rsce_pkg::QPTR_W'(rsce_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == rsce_pkg::QPTR_W'(rsce_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rsce_back.sv @@
// Back end: turns a decoded code into its signed value in the output register.
`default_nettype none

module rsce_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rsce_pkg::t_code_req           i_req,
    input  wire logic                          i_req_valid,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [rsce_pkg::CODE_W-1:0] o_status_code
);

    logic                               r_valid;
    logic signed [rsce_pkg::CODE_W-1:0] r_code;
    logic [rsce_pkg::MAG_W-1:0]         mag;
    logic [rsce_pkg::CODE_W-1:0]        mag_ext;
    logic [rsce_pkg::CODE_W-1:0]        n_code;

    assign o_pop = i_req_valid && (!r_valid || !i_stall);

    assign mag     = rsce_pkg::MAG_W'(i_req.hundreds) * rsce_pkg::MAG_W'(100) +
                     rsce_pkg::MAG_W'(i_req.tens) * rsce_pkg::MAG_W'(10) +
                     rsce_pkg::MAG_W'(i_req.ones);
    assign mag_ext = {1'b0, mag};
    assign n_code  = i_req.neg ? (~mag_ext + 1'b1) : mag_ext;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_code <= $signed(n_code);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid       = r_valid;
    assign o_status_code = r_code;

endmodule

`default_nettype wire

@@ hw/rtl/rsce_checker.sv @@
// Port level checks for the status code extractor and their binding.
`default_nettype none

`include "response_status_code_extractor_defines.svh"

module rsce_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_valid,
    input  wire logic                          i_stall,
    input  wire logic signed [rsce_pkg::CODE_W-1:0] o_status_code
);

    // A zero code never becomes a result.
    `RSCE_ASSERT_NOW(a_no_zero_code, i_clk, i_rst_n, o_valid, o_status_code != '0, "zero code emitted")

    // Three code bytes bound the value.
    `RSCE_ASSERT_NOW(a_code_range, i_clk, i_rst_n, o_valid, (o_status_code >= -11'sd99) && (o_status_code <= 11'sd999), "code out of range")

    `RSCE_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped while stalled")

    `RSCE_ASSERT_NEXT(a_code_holds, i_clk, i_rst_n, o_valid && i_stall, $stable(o_status_code), "result changed while stalled")

endmodule

bind response_status_code_extractor rsce_checker u_rsce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status_code (o_status_code)
);

`default_nettype wire
